// ===== rtl/cmr_pkg.sv =====
// Shared types, constants and the CRC-16/XMODEM byte update for the CAN reassembler.
// No dependencies.
`default_nettype none
package cmr_pkg;
   localparam int SLOT_COUNT_DEF   = 10;
   localparam int PACKET_BYTES_DEF = 512;

   localparam logic [1:0] FUNC_FILL       = 2'd0;
   localparam logic [1:0] FUNC_FILL_LONG  = 2'd1;
   localparam logic [1:0] FUNC_PROCESS    = 2'd2;
   localparam logic [1:0] FUNC_SHORT      = 2'd3;

   localparam logic [2:0] ST_DATA     = 3'd0;
   localparam logic [2:0] ST_ACCEPTED = 3'd1;
   localparam logic [2:0] ST_UNKNOWN  = 3'd2;
   localparam logic [2:0] ST_CRC_BAD  = 3'd3;
   localparam logic [2:0] ST_NO_SLOT  = 3'd4;

   localparam logic [7:0] CMD_STORE   = 8'd0;
   localparam logic [7:0] CMD_DELIVER = 8'd1;
   localparam logic [7:0] CMD_PROCESS = 8'd2;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
      end
      return c;
   endfunction
endpackage
`default_nettype wire

// ===== rtl/can_multiframe_reassembler_top.sv =====
// CAN multi-frame reassembler: slot table, payload memory and control sequencer.
// Depends on cmr_pkg.
//
// Frames for own_id fill reassembly slots byte by byte (CRC-16/XMODEM on the way) and
// process frames with the deliver command deliver the stored packet as 8-byte words
// from a one-port payload memory with a registered read. A request holds the input
// through accept, slot match and result, plus a read and a write back for each payload
// byte appended; a delivering process request takes accept and match plus a read and
// an output for each word. A result still waiting on rsp_tready stalls the match and
// each delivered word. The slot search over the flip-flop slot table and the
// byte-serial CRC/memory update set this sequence.
// Payload memory is not cleared: unwritten lanes are masked on delivery.
`default_nettype none
module can_multiframe_reassembler_top
   import cmr_pkg::*;
#(
   parameter int SLOT_COUNT   = SLOT_COUNT_DEF,
   parameter int PACKET_BYTES = PACKET_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // func[1:0], target_id[9:2], frame_length[13:10], data_byte0..7[77:14], zero pad
   input  wire logic [79:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // status[2:0], source_id[10:3], slot_number[14:11], payload_word[78:15],
   // byte_count[82:79], zero pad
   output logic [87:0]      rsp_tdata,
   output logic             rsp_tlast
);
   localparam int SW    = (PACKET_BYTES + 7) / 8;
   localparam int DEPTH = SLOT_COUNT * SW;
   localparam int AW    = $clog2(DEPTH);
   localparam int WW    = (SW > 1) ? $clog2(SW) : 1;
   localparam int FW    = $clog2(PACKET_BYTES + 1);
   localparam int SELW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   typedef enum logic [2:0] {S_IDLE, S_MATCH, S_FILL_RD, S_FILL_WR, S_DLV_RD, S_DLV_OUT,
                             S_OUT} state_type;

   state_type    state_ff;
   logic [7:0]   own_id_ff;
   logic [SLOT_COUNT-1:0] busy_ff;
   logic [FW-1:0] cnt_ff [SLOT_COUNT];
   logic [15:0]  crc_ff [SLOT_COUNT];
   logic [63:0]  mem [DEPTH];
   logic [63:0]  rd_ff;

   logic [1:0]   func_ff;
   logic [3:0]   len_ff;
   logic [7:0]   d_ff [8];
   logic [SELW-1:0] sel_ff;
   logic [3:0]   bi_ff;    // next frame byte index
   logic [3:0]   bend_ff;  // end byte index
   logic [WW-1:0] wi_ff;
   logic [FW-1:0] rem_ff;

   logic [87:0]  out_ff;
   logic         last_ff, ov_ff;

   // slot search
   logic [15:0]  key;
   logic [SELW-1:0] hit;
   logic         found;
   always_comb begin
      key = (func_ff == FUNC_PROCESS) ? {d_ff[2], d_ff[3]} :
            (func_ff == FUNC_FILL_LONG) ? {d_ff[0], d_ff[1]} : {8'h00, d_ff[0]};
      hit = '0;
      found = 1'b0;
      for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
         if ((func_ff != FUNC_PROCESS && key == 16'h0000) ? !busy_ff[s] :
             (busy_ff[s] && {{(16-FW){1'b0}}, cnt_ff[s]} == key)) begin
            hit = SELW'(s);
            found = 1'b1;
         end
      end
   end

   logic [3:0] hdr;
   logic [3:0] nfill;
   assign hdr = (func_ff == FUNC_FILL_LONG) ? 4'd2 : 4'd1;
   assign nfill = len_ff - hdr;

   logic [FW-1:0] pos;
   logic [AW-1:0] addr;
   logic [AW-1:0] dlv_addr;
   assign pos = cnt_ff[sel_ff];
   assign addr = AW'(sel_ff * SW + (pos >> 3));
   assign dlv_addr = AW'(sel_ff * SW + wi_ff);

   logic [3:0] len_in;
   assign len_in = (req_tdata[13:10] > 4'd8) ? 4'd8 : req_tdata[13:10];
   logic       req_ok;
   always_comb begin
      req_ok = req_tdata[9:2] == own_id_ff;
      case (req_tdata[1:0])
         FUNC_FILL:      req_ok = req_ok && len_in >= 4'd1;
         FUNC_FILL_LONG: req_ok = req_ok && len_in >= 4'd2;
         FUNC_PROCESS:   req_ok = req_ok && len_in >= 4'd6;
         default:        req_ok = req_ok && len_in >= 4'd3;
      endcase
   end

   logic [63:0] short_val;
   always_comb begin
      short_val = '0;
      for (int i = 0; i < 6; i++)
         if (4'(i) < len_ff - 4'd2) short_val[i*8 +: 8] = d_ff[i+2];
   end

   logic [63:0] mask;
   logic [3:0]  bc;
   always_comb begin
      bc = (rem_ff > FW'(8)) ? 4'd8 : 4'(rem_ff);
      mask = '0;
      for (int i = 0; i < 8; i++) if (4'(i) < bc) mask[i*8 +: 8] = 8'hFF;
   end

   logic ov_set;
   assign ov_set = (state_ff == S_OUT) || (state_ff == S_DLV_OUT && (!ov_ff || rsp_tready));

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = out_ff;
   assign rsp_tlast  = last_ff;

   function automatic logic [87:0] pack(input logic [2:0] st, input logic [7:0] src,
                                        input logic [3:0] sl, input logic [63:0] w,
                                        input logic [3:0] n);
      return {5'd0, n, w, sl, src, st};
   endfunction

   always_ff @(posedge clock) begin
      if (state_ff == S_FILL_WR)
         mem[addr] <= (rd_ff & ~(64'hFF << {pos[2:0], 3'b000}))
                      | ({56'd0, d_ff[bi_ff[2:0]]} << {pos[2:0], 3'b000});
      if (state_ff == S_FILL_RD || state_ff == S_DLV_RD)
         rd_ff <= mem[(state_ff == S_DLV_RD) ? dlv_addr : addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         own_id_ff <= '0;
         busy_ff   <= '0;
         ov_ff     <= 1'b0;
         for (int s = 0; s < SLOT_COUNT; s++) begin
            cnt_ff[s] <= '0;
            crc_ff[s] <= '0;
         end
      end else begin
         if (csr_wr_en) own_id_ff <= csr_wr_data;
         if (ov_set) ov_ff <= 1'b1;
         else if (rsp_tready) ov_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid && req_ok) begin
                  func_ff <= req_tdata[1:0];
                  len_ff  <= len_in;
                  for (int i = 0; i < 8; i++) d_ff[i] <= req_tdata[14 + i*8 +: 8];
                  state_ff <= S_MATCH;
               end
            end
            S_MATCH: begin
               if (!ov_ff || rsp_tready) begin
                  sel_ff <= hit;
                  last_ff <= 1'b1;
                  if (func_ff == FUNC_SHORT) begin
                     out_ff <= pack(ST_DATA, d_ff[0], 4'd0, short_val, len_ff - 4'd2);
                     state_ff <= S_OUT;
                  end else if (func_ff != FUNC_PROCESS) begin
                     if (!found || 32'(cnt_ff[hit]) + 32'(nfill) > PACKET_BYTES) begin
                        out_ff <= pack(ST_NO_SLOT, 8'd0, 4'd0, 64'd0, 4'd0);
                        state_ff <= S_OUT;
                     end else begin
                        busy_ff[hit] <= 1'b1;
                        out_ff <= pack(ST_ACCEPTED, 8'd0, 4'(hit), 64'd0, 4'd0);
                        bi_ff <= hdr;
                        bend_ff <= len_ff;
                        state_ff <= (nfill != 4'd0) ? S_FILL_RD : S_OUT;
                     end
                  end else if (!found) begin
                     out_ff <= pack(ST_NO_SLOT, d_ff[0], 4'd0, 64'd0, 4'd0);
                     state_ff <= S_OUT;
                  end else begin
                     busy_ff[hit] <= 1'b0;
                     cnt_ff[hit] <= '0;
                     crc_ff[hit] <= '0;
                     if (crc_ff[hit] != {d_ff[4], d_ff[5]}) begin
                        out_ff <= pack(ST_CRC_BAD, d_ff[0], 4'(hit), 64'd0, 4'd0);
                        state_ff <= S_OUT;
                     end else if (d_ff[1] != CMD_DELIVER || cnt_ff[hit] == '0) begin
                        out_ff <= pack((d_ff[1] == CMD_STORE || d_ff[1] == CMD_DELIVER
                                       || d_ff[1] == CMD_PROCESS) ? ST_ACCEPTED
                                       : ST_UNKNOWN, d_ff[0], 4'(hit), 64'd0, 4'd0);
                        state_ff <= S_OUT;
                     end else begin
                        rem_ff <= cnt_ff[hit];
                        wi_ff <= '0;
                        state_ff <= S_DLV_RD;
                     end
                  end
               end
            end
            S_FILL_RD: state_ff <= S_FILL_WR;
            S_FILL_WR: begin
               crc_ff[sel_ff] <= crc_byte(crc_ff[sel_ff], d_ff[bi_ff[2:0]]);
               cnt_ff[sel_ff] <= pos + FW'(1);
               bi_ff <= bi_ff + 4'd1;
               state_ff <= (bi_ff + 4'd1 == bend_ff) ? S_OUT : S_FILL_RD;
            end
            S_DLV_RD: state_ff <= S_DLV_OUT;
            S_DLV_OUT: begin
               if (!ov_ff || rsp_tready) begin
                  out_ff <= pack(ST_DATA, d_ff[0], 4'(sel_ff), rd_ff & mask, bc);
                  last_ff <= rem_ff <= FW'(8);
                  if (rem_ff <= FW'(8)) state_ff <= S_IDLE;
                  else begin
                     rem_ff <= rem_ff - FW'(8);
                     wi_ff <= wi_ff + WW'(1);
                     state_ff <= S_DLV_RD;
                  end
               end
            end
            S_OUT: begin
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire
